// File: rtl/mbp_pkg.sv
`default_nettype none

package mbp_pkg;

    // Field widths of the channels.
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    // Largest number of bits one item may append; wider requests saturate here.
    localparam logic [COUNT_W-1:0] MAX_WIDTH = COUNT_W'(64);

    // The working window holds a partial byte plus one full value.
    localparam int WIN_W = VALUE_W + BYTE_W;

    // Input item as it arrives on the input channel.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] width;
        logic               end_of_message;
    } in_item_t;

    // Result item as it leaves on the output channel.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              padded;
    } out_item_t;

    // Classified item: bits left aligned and masked, width saturated.
    typedef struct packed {
        logic [VALUE_W-1:0] bits;
        logic [COUNT_W-1:0] width;
        logic               eom;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/mbp_front.sv
`default_nettype none

module mbp_front
    import mbp_pkg::*;
(
    input  wire in_item_t item,
    output job_t          job
);

    logic [COUNT_W-1:0] sat_width;
    logic [COUNT_W-1:0] shift_amt;

    // Saturate the width and push the wanted bits to the top of the word.
    // The left shift also discards every bit above the given width.
    always_comb
    begin
        sat_width = (item.width > MAX_WIDTH) ? MAX_WIDTH : item.width;
        shift_amt = COUNT_W'(VALUE_W) - sat_width;
        job.bits  = item.value << shift_amt;
        job.width = sat_width;
        job.eom   = item.end_of_message;
    end

endmodule

`default_nettype wire

// File: rtl/mbp_queue.sv
`default_nettype none

module mbp_queue
    import mbp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  wire job_t  push_data,
    output logic       full,
    input  wire        pop,
    output logic       head_valid,
    output job_t       head_data
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Status seen by both sides.
    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued items needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mbp_back.sv
`default_nettype none

module mbp_back
    import mbp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        head_valid,
    input  wire job_t  head_data,
    output logic       pop,
    output logic       out_valid,
    input  wire        out_ready,
    output out_item_t  out_data
);

    logic               act_reg;
    logic               act_next;
    logic [WIN_W-1:0]   win_reg;
    logic [WIN_W-1:0]   win_next;
    logic [COUNT_W-1:0] n_reg;
    logic [COUNT_W-1:0] n_next;
    logic               eom_reg;
    logic               eom_next;
    logic [BYTE_W-1:0]  pend_reg;
    logic [BYTE_W-1:0]  pend_next;
    logic [2:0]         pcnt_reg;
    logic [2:0]         pcnt_next;
    logic               ov_reg;
    logic               ov_next;
    out_item_t          od_reg;
    out_item_t          od_next;

    logic               emit_full;
    logic               emit_pad;
    logic               emit;
    logic               out_free;
    logic               step;
    logic [COUNT_W-1:0] n_after;
    logic               rem_emit;
    logic               done;
    logic [BYTE_W-1:0]  left_bits;
    logic [2:0]         left_cnt;
    logic [BYTE_W-1:0]  cur_bits;
    logic [2:0]         cur_cnt;
    logic               load;

    // Decide what the current item emits this cycle.
    always_comb
    begin
        emit_full = act_reg && (n_reg >= COUNT_W'(BYTE_W));
        emit_pad  = act_reg && (n_reg < COUNT_W'(BYTE_W)) && eom_reg && (n_reg != '0);
        emit      = emit_full || emit_pad;
        out_free  = !ov_reg || out_ready;
        step      = emit && out_free;
        n_after   = n_reg - COUNT_W'(BYTE_W);
        rem_emit  = emit_full && ((n_after >= COUNT_W'(BYTE_W))
                                  || (eom_reg && (n_after != '0)));
        done      = act_reg && (!emit || (step && !rem_emit));
    end

    // Bits left over once the item is finished.
    always_comb
    begin
        if (!emit)
        begin
            left_bits = win_reg[WIN_W-1 -: BYTE_W];
            left_cnt  = n_reg[2:0];
        end
        else if (emit_pad)
        begin
            left_bits = '0;
            left_cnt  = '0;
        end
        else
        begin
            left_bits = win_reg[WIN_W-BYTE_W-1 -: BYTE_W];
            left_cnt  = n_after[2:0];
        end
        cur_bits = done ? left_bits : pend_reg;
        cur_cnt  = done ? left_cnt : pcnt_reg;
        load     = head_valid && (!act_reg || done);
        pop      = load;
    end

    // Window, held bits and output register.
    always_comb
    begin
        act_next  = act_reg;
        win_next  = win_reg;
        n_next    = n_reg;
        eom_next  = eom_reg;
        pend_next = done ? left_bits : pend_reg;
        pcnt_next = done ? left_cnt : pcnt_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;

        if (step)
        begin
            win_next = win_reg << BYTE_W;
            n_next   = emit_pad ? '0 : n_after;
        end

        if (load)
        begin
            act_next = 1'b1;
            win_next = {cur_bits, {VALUE_W{1'b0}}}
                       | ({head_data.bits, {BYTE_W{1'b0}}} >> cur_cnt);
            n_next   = COUNT_W'(cur_cnt) + head_data.width;
            eom_next = head_data.eom;
        end
        else if (done)
        begin
            act_next = 1'b0;
        end

        if (step)
        begin
            ov_next             = 1'b1;
            od_next.out_byte    = win_reg[WIN_W-1 -: BYTE_W];
            od_next.last_of_run = emit_pad || !rem_emit;
            od_next.padded      = emit_pad;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            pend_reg <= '0;
            pcnt_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            ov_reg   <= ov_next;
        end
    end

    // Window and result payload need no reset.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        n_reg   <= n_next;
        eom_reg <= eom_next;
        od_reg  <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // The window never holds more than seven held bits plus one full value.
    assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (n_reg <= COUNT_W'(VALUE_W + BYTE_W - 1)))
        else $error("window bit count out of range");

    // A padded byte always closes the run of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && od_reg.padded) |-> od_reg.last_of_run)
        else $error("padded byte not marked last");

    // Finishing a flushing item leaves nothing held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && eom_reg) |=> (pcnt_reg == 3'd0))
        else $error("bits held after end of message");

    // A byte is only moved into the output register when it has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(od_reg)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_packer.sv
`default_nettype none

// MSB-first bit packer. Each input item appends the low width bits of value
// (width saturates at 64) to a byte stream, most significant bit first, and
// every byte that fills leaves on the output channel with its first bit in
// bit 7; end_of_message flushes a partial byte padded with zeros on the low
// side, and last_of_run marks the final byte an item causes. An item
// occupies the emitting stage until it has emitted every byte it completes,
// and the output register takes one byte per cycle unless the receiver
// stalls it. A two-entry queue sits between the classifying front and the
// emitting stage, so input items are taken while earlier bytes are still
// being delivered.
module msb_first_bit_packer
    import mbp_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire             out_ready,
    output out_item_t       out_data
);

    job_t job;
    job_t head_data;
    logic full;
    logic head_valid;
    logic pop;

    // Classify the incoming item.
    mbp_front u_front (
        .item (in_data),
        .job  (job)
    );

    // Decouple acceptance from byte emission.
    assign in_ready = !full;

    mbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_data  (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Pack bits and emit bytes.
    mbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// File: verif/msb_first_bit_packer_tb.sv
`timescale 1ns / 100ps

module msb_first_bit_packer_tb;

    import mbp_pkg::*;

    localparam int          CLK_HALF       = 10;
    localparam int          RESET_CYCLES   = 10;
    localparam int          ITEMS_PER_RUN  = 60;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          HOLD_CYCLES    = 300;
    localparam int unsigned CYCLE_LIMIT    = 600000;

    // Tracks the bit position of the packed stream and the bytes still owed.
    class byte_stream_scoreboard;
        logic [6:0]  held_bits;
        logic [2:0]  held_count;
        out_item_t   expected_bytes[$];
        int unsigned items_seen;
        int unsigned bytes_seen;
        int unsigned padded_seen;
        int unsigned fails;

        function new();
            held_bits   = '0;
            held_count  = '0;
            items_seen  = 0;
            bytes_seen  = 0;
            padded_seen = 0;
            fails       = 0;
        endfunction

        // Appends the item's bits and queues every byte that they complete.
        function void note_item(in_item_t it);
            out_item_t   run_bytes[$];
            out_item_t   b;
            logic [7:0]  acc;
            int unsigned cnt;
            int unsigned n_bits;
            n_bits = (it.width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(it.width);
            acc    = {1'b0, held_bits};
            cnt    = held_count;
            for (int i = n_bits; i > 0; i--)
            begin
                acc = {acc[6:0], it.value[i-1]};
                cnt++;
                if (cnt == 8)
                begin
                    b.out_byte    = acc;
                    b.last_of_run = 1'b0;
                    b.padded      = 1'b0;
                    run_bytes.insert(run_bytes.size(), b);
                    acc = '0;
                    cnt = 0;
                end
            end
            // A flush pads the partial byte with zeros on its low side.
            if (it.end_of_message && cnt > 0)
            begin
                b.out_byte    = acc << (8 - cnt);
                b.last_of_run = 1'b0;
                b.padded      = 1'b1;
                run_bytes.insert(run_bytes.size(), b);
                acc = '0;
                cnt = 0;
            end
            if (run_bytes.size() > 0)
                run_bytes[run_bytes.size()-1].last_of_run = 1'b1;
            foreach (run_bytes[k])
                expected_bytes.insert(expected_bytes.size(), run_bytes[k]);
            held_bits  = acc[6:0];
            held_count = cnt[2:0];
            items_seen++;
        endfunction

        // Compares a delivered byte with the oldest one owed.
        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte %02h with no item outstanding", got.out_byte);
                fails++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_seen++;
            if (got.padded)
                padded_seen++;
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                       got.last_of_run);
                fails++;
            end
            if (got.padded !== want.padded)
            begin
                $error("padded: expected %0b, got %0b", want.padded, got.padded);
                fails++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    byte_stream_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned cycle_count = 0;

    msb_first_bit_packer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock generation.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[msb_first_bit_packer] ERROR");
            $finish;
        end
    end

    // Both handshakes are observed here, inputs before outputs.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_byte(out_data);
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        static int unsigned hold_left = 0;
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one item after any random idle gap and waits until it is taken.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [VALUE_W-1:0] value,
                               input logic [COUNT_W-1:0] width,
                               input logic eom);
        in_item_t it;
        it.value          = value;
        it.width          = width;
        it.end_of_message = eom;
        send_item(it);
    endtask

    // Widths lean towards short runs but reach the full and oversized range.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        pick     = $urandom_range(99);
        it.value = {$urandom, $urandom};
        if (pick < 8)
            it.width = '0;
        else if (pick < 45)
            it.width = COUNT_W'($urandom_range(8, 1));
        else if (pick < 78)
            it.width = COUNT_W'($urandom_range(63, 9));
        else if (pick < 92)
            it.width = MAX_WIDTH;
        else
            it.width = COUNT_W'($urandom_range(127, 65));
        it.end_of_message = ($urandom_range(3) == 0);
        return it;
    endfunction

    // Holds the input low until every owed byte has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int unsigned idle_pct,
                                    input int unsigned stall_pct,
                                    input bit with_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < ITEMS_PER_RUN; n++)
        begin
            // Midway, the receiver backs off while full-width items keep coming.
            if (with_hold && n == ITEMS_PER_RUN / 2)
            begin
                hold_request = HOLD_CYCLES;
                for (int h = 0; h < 12; h++)
                    send_fields({$urandom, $urandom}, MAX_WIDTH, h[0]);
            end
            send_item(random_item());
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: empty items, flushes, masking, saturation, the longest run.
        send_fields(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b0);
        send_fields(64'h0, 7'd0, 1'b1);
        send_fields(64'h1, 7'd1, 1'b0);
        send_fields(64'hFFFF_FFFF_FFFF_FFF5, 7'd3, 1'b0);
        send_fields(64'h0, 7'd0, 1'b1);
        send_fields(64'hA5, 7'd8, 1'b0);
        send_fields(64'hFFFF_FFFF_FFFF_FFFF, 7'd7, 1'b0);
        send_fields(64'hFFFF_FFFF_FFFF_FFFF, MAX_WIDTH, 1'b1);
        send_fields(64'h7F, 7'd7, 1'b0);
        send_fields(64'h0, MAX_WIDTH, 1'b0);
        send_fields(64'h0123_4567_89AB_CDEF, 7'd127, 1'b0);
        send_fields(64'hFEDC_BA98_7654_3210, 7'd65, 1'b1);
        send_fields(64'h8000_0000_0000_0000, MAX_WIDTH, 1'b1);
        send_fields(64'h5555_5555_5555_5555, 7'd63, 1'b0);
        send_fields(64'hAAAA_AAAA_AAAA_AAAA, 7'd1, 1'b0);
        send_fields(64'h1, 7'd1, 1'b1);
        send_fields(64'hFFFF_FFFF_FFFF_FFFF, 7'd9, 1'b0);
        send_fields(64'h0, 7'd96, 1'b1);
        wait_for_drain();

        run_random_phase(0, 0, 1'b1);
        run_random_phase(77, 0, 1'b0);
        run_random_phase(0, 77, 1'b0);
        run_random_phase(38, 38, 1'b0);

        $display("Packed %0d items into %0d bytes, %0d of them padded flushes,",
                 sb.items_seen, sb.bytes_seen, sb.padded_seen);
        $display("under free flow, sender gaps, receiver stalls, both and a long hold-off.");
        if (sb.fails == 0 && sb.outstanding() == 0)
            $display("[msb_first_bit_packer] OK");
        else
            $display("[msb_first_bit_packer] ERROR");
        $finish;
    end

endmodule
